>>> rtl/rde_pkg.sv
// rde_pkg: shared types, constants and the symbol lookup helper function of the radix digit emitter
// depends on: nothing
`default_nettype none

package rde_pkg;

  localparam int ValueW         = 64;
  localparam int SymW           = 8;
  localparam int TotalW         = 32;
  localparam int RadixW         = 5;
  localparam int DigitW         = 4;
  localparam int MaxRadix       = 16;
  localparam int MaxDigits      = 64;
  localparam int PtrW           = $clog2(MaxDigits);
  localparam int CntW           = PtrW + 1;
  localparam int BitsPerCycle   = 8;
  localparam int CyclesPerDigit = ValueW / BitsPerCycle;
  localparam int StepW          = $clog2(CyclesPerDigit);
  localparam int SymsPerWord    = ValueW / SymW;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSymbolsLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSymbolsHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRadixLength = 2'd2;

  // alphabet limits
  localparam logic [SymW-1:0] CharPlus   = 8'h2b;
  localparam logic [SymW-1:0] CharMinus  = 8'h2d;
  localparam logic [SymW-1:0] CharLowest = 8'd32;
  localparam logic [SymW-1:0] CharHigh   = 8'd126;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              bad;
  } rde_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_RD,
    ST_OUT
  } rde_state_e;

  // symbol lookup: symbols 0..7 from the low word, 8..15 from the high word
  function automatic logic [SymW-1:0] sym_at(input logic [ValueW-1:0] lo,
                                             input logic [ValueW-1:0] hi,
                                             input logic [DigitW-1:0] idx);
    logic [ValueW-1:0] word;
    word = idx[DigitW-1] ? hi : lo;
    return word[idx[DigitW-2:0]*SymW +: SymW];
  endfunction

endpackage

`default_nettype wire

>>> rtl/rde_in_if.sv
// rde_in_if: input channel carrying the value to be converted
// depends on: rde_pkg
`default_nettype none

interface rde_in_if
  import rde_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/rde_out_if.sv
// rde_out_if: output channel carrying one emitted symbol per transaction
// depends on: rde_pkg
`default_nettype none

interface rde_out_if
  import rde_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [SymW-1:0]   symbol;
  logic              last;
  logic              alphabet_error;
  logic [TotalW-1:0] total_emitted;

  modport source (output valid, output symbol, output last, output alphabet_error,
                  output total_emitted, input ready);
  modport sink   (input valid, input symbol, input last, input alphabet_error,
                  input total_emitted, output ready);
endinterface

`default_nettype wire

>>> rtl/rde_front.sv
// rde_front: accepts input transactions and classifies the configured alphabet
// depends on: rde_pkg, rde_in_if
`default_nettype none

module rde_front
  import rde_pkg::*;
(
  rde_in_if.sink            in_s,
  input  wire logic [ValueW-1:0] symbols_low_i,
  input  wire logic [ValueW-1:0] symbols_high_i,
  input  wire logic [RadixW-1:0] radix_len_i,
  output logic              push_o,
  output rde_entry_t        push_data_o,
  input  wire logic         full_i
);

  logic [SymW-1:0] sym [MaxRadix];
  logic            bad;

  always_comb begin
    for (int i = 0; i < MaxRadix; i++) begin
      sym[i] = sym_at(symbols_low_i, symbols_high_i, DigitW'(i));
    end
  end

  // all symbol and pair checks run side by side
  always_comb begin
    bad = (radix_len_i < RadixW'(2)) || (radix_len_i > RadixW'(MaxRadix));
    for (int i = 0; i < MaxRadix; i++) begin
      if (RadixW'(i) < radix_len_i) begin
        if (sym[i] == CharPlus || sym[i] == CharMinus ||
            sym[i] < CharLowest || sym[i] > CharHigh) begin
          bad = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (sym[j] == sym[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign in_s.ready        = !full_i;
  assign push_o            = in_s.valid && !full_i;
  assign push_data_o.value = in_s.value;
  assign push_data_o.bad   = bad;

endmodule

`default_nettype wire

>>> rtl/rde_queue.sv
// rde_queue: two-entry queue between the front and back parts
// depends on: rde_pkg
`default_nettype none

module rde_queue
  import rde_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire rde_entry_t push_data_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output rde_entry_t      pop_data_o
);

  rde_entry_t  slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;

  assign full_o     = (fill_q == 2'd2);
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rde_back.sv
// rde_back: digit extraction with an iterative divider, digit memory and result register
// depends on: rde_pkg, rde_out_if
`default_nettype none

module rde_back
  import rde_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ValueW-1:0] symbols_low_i,
  input  wire logic [ValueW-1:0] symbols_high_i,
  input  wire logic [RadixW-1:0] radix_len_i,
  input  wire logic              q_valid_i,
  input  wire rde_entry_t        q_data_i,
  output logic                   q_pop_o,
  rde_out_if.source              out_s
);

  rde_state_e         state_q, state_d;
  logic [ValueW-1:0]  quo_q, quo_n;
  logic [DigitW-1:0]  rem_q, rem_n;
  logic [StepW-1:0]   step_q;
  logic [CntW-1:0]    cnt_q;
  logic [PtrW-1:0]    ptr_q;
  logic [DigitW-1:0]  rdata_q;
  logic [DigitW-1:0]  digit_mem [MaxDigits];
  logic [TotalW-1:0]  total_q;

  logic               out_valid_q;
  logic [SymW-1:0]    out_sym_q;
  logic               out_last_q;
  logic               out_err_q;
  logic [TotalW-1:0]  out_total_q;

  logic slot_free;
  logic digit_done;
  logic conv_done;
  logic load_err;
  logic load_sym;
  logic mem_we;

  // eight restoring division steps per cycle, remainder stays below the radix
  always_comb begin
    logic [DigitW:0] r5;
    logic [ValueW-1:0] q;
    logic [DigitW-1:0] r;
    q = quo_q;
    r = rem_q;
    for (int i = 0; i < BitsPerCycle; i++) begin
      r5 = {r, q[ValueW-1]};
      q  = {q[ValueW-2:0], 1'b0};
      if (r5 >= radix_len_i) begin
        r5   = r5 - radix_len_i;
        q[0] = 1'b1;
      end
      r = r5[DigitW-1:0];
    end
    quo_n = q;
    rem_n = r;
  end

  assign slot_free  = !out_valid_q || out_s.ready;
  assign digit_done = (step_q == StepW'(CyclesPerDigit - 1));
  assign conv_done  = (quo_n == '0) || (cnt_q == CntW'(MaxDigits - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) state_d = q_data_i.bad ? ST_ERR : ST_DIV;
      ST_ERR:  if (slot_free) state_d = ST_IDLE;
      ST_DIV:  if (digit_done && conv_done) state_d = ST_RD;
      ST_RD:   state_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) state_d = (ptr_q == '0) ? ST_IDLE : ST_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o  = 1'b0;
    load_err = 1'b0;
    load_sym = 1'b0;
    mem_we   = 1'b0;
    case (state_q)
      ST_IDLE: q_pop_o  = q_valid_i;
      ST_ERR:  load_err = slot_free;
      ST_DIV:  mem_we   = digit_done;
      ST_OUT:  load_sym = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        step_q <= '0;
        cnt_q  <= '0;
      end else if (state_q == ST_DIV) begin
        step_q <= step_q + StepW'(1);
        if (digit_done) begin
          cnt_q <= cnt_q + CntW'(1);
          ptr_q <= cnt_q[PtrW-1:0];
        end
      end else if (load_sym) begin
        ptr_q <= ptr_q - PtrW'(1);
      end
      if (load_sym) begin
        total_q <= total_q + TotalW'(1);
      end
      if (load_err || load_sym) begin
        out_valid_q <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      quo_q <= q_data_i.value;
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      quo_q <= quo_n;
      rem_q <= digit_done ? '0 : rem_n;
    end
    if (load_err) begin
      out_sym_q   <= '0;
      out_last_q  <= 1'b1;
      out_err_q   <= 1'b1;
      out_total_q <= total_q;
    end else if (load_sym) begin
      out_sym_q   <= sym_at(symbols_low_i, symbols_high_i, rdata_q);
      out_last_q  <= (ptr_q == '0);
      out_err_q   <= 1'b0;
      out_total_q <= total_q + TotalW'(1);
    end
  end

  // digit memory, least significant digit at address zero
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[PtrW-1:0]] <= rem_n;
    end
    rdata_q <= digit_mem[ptr_q];
  end

  assign out_s.valid          = out_valid_q;
  assign out_s.symbol         = out_sym_q;
  assign out_s.last           = out_last_q;
  assign out_s.alphabet_error = out_err_q;
  assign out_s.total_emitted  = out_total_q;

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_last_q && (out_sym_q == '0))
    else $error("error result without last or with a symbol");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxDigits))
    else $error("digit count beyond memory depth");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_sym |=> total_q == $past(total_q) + TotalW'(1))
    else $error("running count did not advance on a digit");

  a_emit_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> ($past(state_q) == ST_DIV || $past(state_q) == ST_OUT))
    else $error("memory read outside of emission");

endmodule

`default_nettype wire

>>> rtl/radix_digit_emitter_unit.sv
// radix_digit_emitter_unit: the divider finds the digits of an item (D = digit count, 1..64)
// at 8 quotient bits per cycle, least significant first, and stores them in the digit memory;
// the symbols are then read back from the digit memory and offered most significant first
// one item at a time in the back, the next one starts once the last symbol of the one before
// is loaded for output; an invalid alphabet gives one error transaction per item
// reset clears configuration (alphabet invalid), running count, queue and control, not memory
`default_nettype none

module radix_digit_emitter_unit
  import rde_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ValueW-1:0]  cfg_wdata_i,
  rde_in_if.sink                  in_i,
  rde_out_if.source               out_o
);

  // configuration registers, all zero after reset
  logic [ValueW-1:0] symbols_low_q;
  logic [ValueW-1:0] symbols_high_q;
  logic [RadixW-1:0] radix_len_q;

  // front to queue
  logic       push;
  rde_entry_t push_data;
  logic       q_full;

  // queue to back
  logic       q_valid;
  logic       q_pop;
  rde_entry_t q_data;

  // register writes; an index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbols_low_q  <= '0;
      symbols_high_q <= '0;
      radix_len_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSymbolsLow:  symbols_low_q  <= cfg_wdata_i;
        CfgSymbolsHigh: symbols_high_q <= cfg_wdata_i;
        CfgRadixLength: radix_len_q    <= cfg_wdata_i[RadixW-1:0];
        default: ;
      endcase
    end
  end

  // front: takes each transaction and tags it with the alphabet check
  rde_front u_front (
    .in_s           (in_i),
    .symbols_low_i  (symbols_low_q),
    .symbols_high_i (symbols_high_q),
    .radix_len_i    (radix_len_q),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (q_full)
  );

  // short queue of two entries so the front keeps accepting while the back converts, until it fills
  rde_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // back: divides, stores digits, emits them most significant first
  rde_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .symbols_low_i  (symbols_low_q),
    .symbols_high_i (symbols_high_q),
    .radix_len_i    (radix_len_q),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .out_s          (out_o)
  );

endmodule

`default_nettype wire

>>> sim/radix_digit_emitter_unit_test.sv
// radix_digit_emitter_unit_test: self-checking bench for the radix digit emitter
// predicts every digit transaction from a mirror of the alphabet registers and the count
// depends on: rde_pkg, rde_in_if, rde_out_if, radix_digit_emitter_unit
`default_nettype none

module radix_digit_emitter_unit_test;
  import rde_pkg::*;

  // bench timing
  localparam int HoldCycles    = 600;    // one long receiver hold-off
  localparam int TailCycles    = 60;     // quiet cycles after the last digit
  localparam int WatchdogLimit = 20000;  // cycles with no transaction on either side
  localparam int RandomPhases  = 10;
  localparam int PhaseItems    = 25;
  localparam int PressurePhase = 2;

  // write to an index that holds no register, must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // directed alphabets, symbol 0 in the low byte
  localparam logic [ValueW-1:0] DecLo  = 64'h3736_3534_3332_3130;  // "01234567"
  localparam logic [ValueW-1:0] DecHi  = 64'h2d2b_ff00_7f1f_3938;  // "89", junk above
  localparam logic [ValueW-1:0] BinLo  = 64'hffff_ffff_ffff_3130;  // "01", junk above
  localparam logic [ValueW-1:0] HexLo  = 64'h3736_3534_3332_3130;
  localparam logic [ValueW-1:0] HexHi  = 64'h6665_6463_6261_3938;  // "89abcdef"
  localparam logic [ValueW-1:0] EdgeLo = 64'h3736_3534_3332_3120;  // space as symbol 0
  localparam logic [ValueW-1:0] EdgeHi = 64'h7e65_6463_6261_3938;  // tilde as symbol 15

  typedef enum int {
    FAULT_NONE,
    FAULT_LENGTH,
    FAULT_PLUS,
    FAULT_MINUS,
    FAULT_LOW,
    FAULT_HIGH,
    FAULT_REPEAT
  } alphabet_fault_e;

  typedef struct packed {
    logic [SymW-1:0]   symbol;
    logic              last;
    logic              alphabet_error;
    logic [TotalW-1:0] total_emitted;
  } digit_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ValueW-1:0]  cfg_wdata_i;

  rde_in_if  value_ch ();
  rde_out_if digit_ch ();

  radix_digit_emitter_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (value_ch),
    .out_o       (digit_ch)
  );

  // mirror of the configuration and of the running symbol count
  logic [ValueW-1:0] alpha_lo;
  logic [ValueW-1:0] alpha_hi;
  logic [RadixW-1:0] radix_len;
  logic [TotalW-1:0] emitted_count;

  logic [ValueW-1:0] values_to_send [$];   // values waiting for the driver
  digit_result_t     expected_digits [$];  // predicted digit transactions, oldest first

  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned hold_left;
  bit          idling;
  bit          hold_request;
  digit_result_t oldest;

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [SymW-1:0] symbol_of(input int idx);
    return (idx < 8) ? alpha_lo[idx*SymW +: SymW] : alpha_hi[(idx-8)*SymW +: SymW];
  endfunction

  // too short or too long, a sign character, a non-printable byte or a repeat
  function automatic bit alphabet_faulty();
    logic [SymW-1:0] c;
    if (radix_len < 2 || radix_len > MaxRadix) return 1'b1;
    for (int i = 0; i < int'(radix_len); i++) begin
      c = symbol_of(i);
      if (c == CharPlus || c == CharMinus || c < CharLowest || c > CharHigh) return 1'b1;
      for (int j = 0; j < i; j++) begin
        if (symbol_of(j) == c) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // queues the digit transactions that one accepted value gives rise to
  task automatic predict_digits(input logic [ValueW-1:0] v);
    logic [DigitW-1:0] digits [MaxDigits];
    logic [ValueW-1:0] rest;
    logic [ValueW-1:0] base;
    digit_result_t     r;
    int                n;
    rest = v;
    base = ValueW'(radix_len);
    n = 0;
    if (alphabet_faulty()) begin
      // one error transaction, count unchanged
      r.symbol         = '0;
      r.last           = 1'b1;
      r.alphabet_error = 1'b1;
      r.total_emitted  = emitted_count;
      expected_digits.push_back(r);
      return;
    end
    // least significant digit first, zero still gives one digit
    do begin
      digits[n] = DigitW'(rest % base);
      rest      = rest / base;
      n++;
    end while (rest != 0 && n < MaxDigits);
    for (int k = n - 1; k >= 0; k--) begin
      emitted_count    = emitted_count + 1'b1;
      r.symbol         = symbol_of(int'(digits[k]));
      r.last           = (k == 0);
      r.alphabet_error = 1'b0;
      r.total_emitted  = emitted_count;
      expected_digits.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                 input logic [ValueW-1:0] want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------

  // one register write per rising edge, mirror follows at once (block is idle)
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValueW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgSymbolsLow:  alpha_lo  = data;
      CfgSymbolsHigh: alpha_hi  = data;
      CfgRadixLength: radix_len = data[RadixW-1:0];
      default: ;
    endcase
  endtask

  // every setting also pokes the unused index with junk
  task automatic apply_config(input logic [ValueW-1:0] lo, input logic [ValueW-1:0] hi,
                              input logic [ValueW-1:0] len_word);
    write_reg(CfgSymbolsLow, lo);
    write_reg(CfgSymbolsHigh, hi);
    write_reg(CfgUnused, {$urandom, $urandom});
    write_reg(CfgRadixLength, len_word);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // random alphabet of distinct printable symbols, optionally spoiled in one way
  task automatic make_alphabet(input alphabet_fault_e fault, output logic [ValueW-1:0] lo,
                               output logic [ValueW-1:0] hi,
                               output logic [ValueW-1:0] len_word);
    bit              taken [256];
    logic [SymW-1:0] sym [MaxRadix];
    logic [SymW-1:0] c;
    int              len;
    int              pos;
    len = $urandom_range(2, MaxRadix);
    for (int i = 0; i < MaxRadix; i++) begin
      if (i < len) begin
        do c = $urandom_range(CharLowest, CharHigh);
        while (c == CharPlus || c == CharMinus || taken[c]);
        taken[c] = 1'b1;
      end else begin
        // slots beyond the radix are never looked at
        c = $urandom_range(0, 255);
      end
      sym[i] = c;
    end
    pos = $urandom_range(0, len - 1);
    case (fault)
      FAULT_LENGTH: len = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                               : $urandom_range(MaxRadix + 1, 31);
      FAULT_PLUS:   sym[pos] = CharPlus;
      FAULT_MINUS:  sym[pos] = CharMinus;
      FAULT_LOW:    sym[pos] = $urandom_range(0, CharLowest - 1);
      FAULT_HIGH:   sym[pos] = $urandom_range(CharHigh + 1, 255);
      FAULT_REPEAT: begin
        pos      = $urandom_range(1, len - 1);
        sym[pos] = sym[$urandom_range(0, pos - 1)];
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      lo[i*SymW +: SymW] = sym[i];
      hi[i*SymW +: SymW] = sym[i + 8];
    end
    // upper bits of the length word are junk the block must drop
    len_word              = {$urandom, $urandom};
    len_word[RadixW-1:0]  = len[RadixW-1:0];
  endtask

  // mostly short values, some wide ones and a few edges
  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return ValueW'($urandom_range(0, 1000));
      5, 6:          return full >> $urandom_range(0, ValueW - 1);
      7, 8:          return full;
      default:       return $urandom_range(0, 1) ? '1
                                                 : (ValueW'(1) << $urandom_range(0, ValueW - 1));
    endcase
  endfunction

  // waits until every queued value went in and every digit came out
  task automatic drain();
    do @(negedge clk_i);
    while (values_to_send.size() != 0 || value_ch.valid || expected_digits.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued values, holds valid until the transaction completes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (value_ch.valid && value_ch.ready) begin
      predict_digits(values_to_send.pop_front());
    end
    if (value_ch.valid && !value_ch.ready) begin
      // keep offering the same value
    end else if (send_gap > 0) begin
      send_gap--;
      value_ch.valid <= 1'b0;
    end else if (values_to_send.size() == 0) begin
      value_ch.valid <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      // idle burst
      send_gap       = $urandom_range(0, 2);
      value_ch.valid <= 1'b0;
    end else begin
      value_ch.valid <= 1'b1;
      value_ch.value <= values_to_send[0];
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each digit transaction, throttles ready
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (digit_ch.valid && digit_ch.ready) begin
      if (expected_digits.size() == 0) begin
        report_mismatch("unexpected transaction, symbol", ValueW'(digit_ch.symbol), '0);
      end else begin
        oldest = expected_digits.pop_front();
        if (digit_ch.symbol !== oldest.symbol)
          report_mismatch("symbol", ValueW'(digit_ch.symbol), ValueW'(oldest.symbol));
        if (digit_ch.last !== oldest.last)
          report_mismatch("last", ValueW'(digit_ch.last), ValueW'(oldest.last));
        if (digit_ch.alphabet_error !== oldest.alphabet_error)
          report_mismatch("alphabet_error", ValueW'(digit_ch.alphabet_error),
                          ValueW'(oldest.alphabet_error));
        if (digit_ch.total_emitted !== oldest.total_emitted)
          report_mismatch("total_emitted", ValueW'(digit_ch.total_emitted),
                          ValueW'(oldest.total_emitted));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      digit_ch.ready <= 1'b0;
    end else if (hold_request) begin
      // long hold-off so the block backs up into its input
      hold_request   = 1'b0;
      hold_left      = HoldCycles;
      digit_ch.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      digit_ch.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      recv_stall     = $urandom_range(0, 2);
      digit_ch.ready <= 1'b0;
    end else begin
      digit_ch.ready <= 1'b1;
    end
  end

  // watchdog: no transaction on either side for too long ends the run
  always @(posedge clk_i) begin
    if ((value_ch.valid && value_ch.ready) || (digit_ch.valid && digit_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no transaction for %0d cycles", WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [ValueW-1:0] lo;
    logic [ValueW-1:0] hi;
    logic [ValueW-1:0] len_word;
    alphabet_fault_e   fault;

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    digit_ch.ready = 1'b0;
    alpha_lo       = '0;
    alpha_hi       = '0;
    radix_len      = '0;
    emitted_count  = '0;
    mismatches     = 0;
    quiet_cycles   = 0;
    send_gap       = 0;
    recv_stall     = 0;
    hold_left      = 0;
    hold_request   = 1'b0;
    idling         = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset alphabet is empty, so only error transactions
    values_to_send.push_back('0);
    values_to_send.push_back('1);
    drain();

    // decimal, including zero and the largest value
    apply_config(DecLo, DecHi, 64'd10);
    values_to_send.push_back(64'd0);
    values_to_send.push_back(64'd9);
    values_to_send.push_back(64'd10);
    values_to_send.push_back('1);
    values_to_send.push_back(64'h8000_0000_0000_0000);
    drain();

    // binary gives the longest digit string
    apply_config(BinLo, '0, 64'd2);
    values_to_send.push_back(64'd0);
    values_to_send.push_back(64'd1);
    values_to_send.push_back('1);
    drain();

    // full-size alphabet with the lowest and highest printable symbols
    apply_config(EdgeLo, EdgeHi, 64'd16);
    values_to_send.push_back(64'd0);
    values_to_send.push_back('1);
    values_to_send.push_back(64'h0123_4567_89ab_cdef);
    drain();

    // radix of one
    apply_config(DecLo, DecHi, 64'd1);
    values_to_send.push_back(64'd5);
    drain();
    // radix one beyond the maximum
    apply_config(HexLo, HexHi, 64'd17);
    values_to_send.push_back('1);
    drain();
    // largest length field, upper data bits all set
    apply_config(HexLo, HexHi, '1);
    values_to_send.push_back(64'd3);
    drain();
    // plus sign in use
    apply_config(64'h3736_3534_2b32_3130, DecHi, 64'd10);
    values_to_send.push_back(64'd123);
    drain();
    // minus sign in use
    apply_config(DecLo, 64'h0000_0000_0000_2d38, 64'd10);
    values_to_send.push_back(64'd77);
    drain();
    // byte just below the printable range
    apply_config(64'h3736_3534_3332_311f, DecHi, 64'd10);
    values_to_send.push_back(64'd0);
    drain();
    // byte just above the printable range
    apply_config(HexLo, 64'h7f65_6463_6261_3938, 64'd16);
    values_to_send.push_back(64'd255);
    drain();
    // repeated symbol
    apply_config(HexLo, 64'h6165_6463_6261_3938, 64'd16);
    values_to_send.push_back(64'd4096);
    drain();

    // random alphabets and values, mostly valid; no idling in the last phases
    for (int phase = 0; phase < RandomPhases; phase++) begin
      fault = (phase != 0 && phase != PressurePhase && $urandom_range(0, 5) == 0)
              ? alphabet_fault_e'($urandom_range(FAULT_LENGTH, FAULT_REPEAT)) : FAULT_NONE;
      make_alphabet(fault, lo, hi, len_word);
      apply_config(lo, hi, len_word);
      if (phase >= RandomPhases - 2) idling = 1'b0;
      if (phase == PressurePhase) hold_request = 1'b1;
      for (int n = 0; n < PhaseItems; n++) values_to_send.push_back(random_value());
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/rde_pkg.sv
rtl/rde_in_if.sv
rtl/rde_out_if.sv
rtl/rde_front.sv
rtl/rde_queue.sv
rtl/rde_back.sv
rtl/radix_digit_emitter_unit.sv
sim/radix_digit_emitter_unit_test.sv
